[src/triggered_adc_capture_sequencer_macros.svh]
// assertion macros for the triggered adc capture sequencer
`ifndef TRIGGERED_ADC_CAPTURE_SEQUENCER_MACROS_SVH
`define TRIGGERED_ADC_CAPTURE_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TACS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tacs: property violated");

`define TACS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tacs: next-cycle property violated");

`else

`define TACS_ASSERT(lbl, prop)

`define TACS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/tacs_pkg.sv]
// types, codes and reset values shared by the capture sequencer
`timescale 1ns / 1ps

package tacs_pkg;

  localparam int unsigned BufferDepthDefault = 256;
  localparam int unsigned SensorSlotsDefault = 3;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CFG_TRIGGER_THRESHOLD = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_MAX_TEST_TRIES    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_CAPTURE_LENGTH    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_OVERSAMPLE_COUNT  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_THERMISTOR_SLOT   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_HUMIDITY_SLOT     = 3'd5;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_ACK    = 2'd2;

  localparam logic [7:0] ByteMask = 8'hFF;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_TESTING    = 3'd1,
    MODE_CONTINUOUS = 3'd2,
    MODE_UNSTABLE   = 3'd3,
    MODE_ONE_SHOT   = 3'd4,
    MODE_DONE       = 3'd5,
    MODE_ERROR      = 3'd6
  } mode_e;

  typedef struct packed {
    logic [9:0]  trigger_threshold;
    logic [15:0] max_test_tries;
    logic [15:0] capture_length;
    logic [6:0]  oversample_count;
    logic [2:0]  thermistor_slot;
    logic [2:0]  humidity_slot;
  } tacs_cfg_t;

  localparam tacs_cfg_t CFG_RESET = '{
    trigger_threshold: 10'd512,
    max_test_tries:    16'd1000,
    capture_length:    16'd200,
    oversample_count:  7'd16,
    thermistor_slot:   3'd1,
    humidity_slot:     3'd2
  };

  typedef struct packed {
    mode_e       mode;
    logic        started;
    logic [15:0] try_cnt;
    logic [15:0] timer;
    logic [15:0] interval;
    logic [47:0] ticks;
    logic [2:0]  slot;
    logic [7:0]  os_cnt;
    logic [15:0] therm;
    logic [15:0] hum;
  } tacs_state_t;

  localparam tacs_state_t STATE_RESET = '{
    mode:     MODE_IDLE,
    started:  1'b0,
    try_cnt:  16'd0,
    timer:    16'd0,
    interval: 16'd0,
    ticks:    48'd0,
    slot:     3'd0,
    os_cnt:   8'd0,
    therm:    16'd0,
    hum:      16'd0
  };

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  mux_slot;
    logic        buf_write;
    logic [7:0]  buf_index;
    logic [7:0]  buf_byte;
    logic [7:0]  capture_phase;
    logic [47:0] trigger_ticks_total;
    logic [15:0] thermistor_sum;
    logic [15:0] humidity_sum;
    logic        adc_disable;
    logic        capture_done_toggle;
  } tacs_result_t;

  localparam int unsigned OutDataW = 120;

endpackage

[src/triggered_adc_capture_sequencer.sv]
// Triggered ADC capture sequencer, top level. One transfer in gives one result
// transfer out. A transfer is taken every clock cycle while the single result
// register is empty or its result is taken in the same cycle, so the sustained rate
// is one item per cycle, set by the state update loop from the sequencer registers
// through the step logic and back. Configuration is to be written through the cfg
// port only while no transfer is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`include "triggered_adc_capture_sequencer_macros.svh"

module triggered_adc_capture_sequencer #(
  parameter int unsigned BUFFER_DEPTH = tacs_pkg::BufferDepthDefault,
  parameter int unsigned SENSOR_SLOTS = tacs_pkg::SensorSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tacs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tacs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // adc_value
  input  logic [1:0]                     s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // mode, mux_slot, buf_write, buf_index, buf_byte, capture_phase,
  // trigger_ticks_total, thermistor_sum, humidity_sum, adc_disable, capture_done_toggle
  output logic [tacs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import tacs_pkg::*;

  localparam int unsigned PosW = $clog2(BUFFER_DEPTH);

  tacs_cfg_t    cfg_q;
  tacs_state_t  state_q, state_d;
  logic [PosW-1:0] wr_pos_q, wr_pos_d;
  tacs_result_t result;
  logic         out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic         in_xfer;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRIGGER_THRESHOLD: cfg_q.trigger_threshold <= cfg_data_i[9:0];
        CFG_MAX_TEST_TRIES:    cfg_q.max_test_tries    <= cfg_data_i;
        CFG_CAPTURE_LENGTH:    cfg_q.capture_length    <= cfg_data_i;
        CFG_OVERSAMPLE_COUNT:  cfg_q.oversample_count  <= cfg_data_i[6:0];
        CFG_THERMISTOR_SLOT:   cfg_q.thermistor_slot   <= cfg_data_i[2:0];
        CFG_HUMIDITY_SLOT:     cfg_q.humidity_slot     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  tacs_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .SENSOR_SLOTS(SENSOR_SLOTS),
    .PosW        (PosW)
  ) u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .wr_pos_i   (wr_pos_q),
    .req_type_i (s_axis_tuser),
    .adc_value_i(s_axis_tdata[9:0]),
    .state_o    (state_d),
    .wr_pos_o   (wr_pos_d),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= STATE_RESET;
      wr_pos_q <= '0;
    end else if (in_xfer) begin
      state_q  <= state_d;
      wr_pos_q <= wr_pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {7'd0,
                     result.capture_done_toggle,
                     result.adc_disable,
                     result.humidity_sum,
                     result.thermistor_sum,
                     result.trigger_ticks_total,
                     result.capture_phase,
                     result.buf_byte,
                     result.buf_index,
                     result.buf_write,
                     result.mux_slot,
                     result.mode};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // error is terminal
  `TACS_ASSERT_NEXT(a_error_sticky, state_q.mode == MODE_ERROR, state_q.mode == MODE_ERROR)
  // the capture timer runs only during continuous capture
  `TACS_ASSERT(a_timer_in_cont, state_q.timer != 16'd0 |-> state_q.mode == MODE_CONTINUOUS)
  // nothing leaves idle before the first start pulse
  `TACS_ASSERT(a_idle_until_start, !state_q.started |-> state_q.mode == MODE_IDLE)
  // a capture-done result always leaves the block settling on slot 1
  `TACS_ASSERT(a_done_to_unstable,
    out_valid_q && out_data_q[112] |-> out_data_q[2:0] == MODE_UNSTABLE && out_data_q[5:3] == 3'd1)

endmodule

[src/tacs_step.sv]
// next-state and result logic for one transfer of the capture sequencer
`timescale 1ns / 1ps

module tacs_step #(
  parameter int unsigned BUFFER_DEPTH = tacs_pkg::BufferDepthDefault,
  parameter int unsigned SENSOR_SLOTS = tacs_pkg::SensorSlotsDefault,
  parameter int unsigned PosW         = $clog2(BUFFER_DEPTH)
) (
  input  tacs_pkg::tacs_cfg_t    cfg_i,
  input  tacs_pkg::tacs_state_t  state_i,
  input  logic [PosW-1:0]        wr_pos_i,
  input  logic [1:0]             req_type_i,
  input  logic [9:0]             adc_value_i,
  output tacs_pkg::tacs_state_t  state_o,
  output logic [PosW-1:0]        wr_pos_o,
  output tacs_pkg::tacs_result_t result_o
);
  import tacs_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(BUFFER_DEPTH - 1);

  function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] p);
    pos_inc = (p == LastPos) ? '0 : p + 1'b1;
  endfunction

  logic [15:0] timer_inc;
  logic [15:0] interval_inc;
  logic [7:0]  os_inc;
  logic [3:0]  slot_inc;

  assign timer_inc    = state_i.timer + 16'd1;
  assign interval_inc = state_i.interval + 16'd1;
  assign os_inc       = state_i.os_cnt + 8'd1;
  assign slot_inc     = {1'b0, state_i.slot} + 4'd1;

  always_comb begin
    state_o                     = state_i;
    wr_pos_o                    = wr_pos_i;
    result_o.buf_write          = 1'b0;
    result_o.buf_index          = 8'd0;
    result_o.buf_byte           = 8'd0;
    result_o.capture_done_toggle = 1'b0;

    unique case (req_type_i)
      REQ_SAMPLE: begin
        if (state_i.started && state_i.mode != MODE_ERROR) begin
          state_o.interval = interval_inc;
          unique case (state_i.mode)
            MODE_TESTING: begin
              if (adc_value_i > cfg_i.trigger_threshold) begin
                state_o.mode = MODE_IDLE;
              end else if (state_i.try_cnt < cfg_i.max_test_tries) begin
                state_o.try_cnt = state_i.try_cnt + 16'd1;
              end else begin
                state_o.mode = MODE_ERROR;
              end
            end
            MODE_CONTINUOUS: begin
              if (state_i.timer != 16'd0) begin
                state_o.timer = timer_inc;
                if (timer_inc == cfg_i.capture_length) begin
                  state_o.timer                = 16'd0;
                  state_o.slot                 = 3'd1;
                  state_o.therm                = 16'd0;
                  state_o.hum                  = 16'd0;
                  state_o.mode                 = MODE_UNSTABLE;
                  result_o.capture_done_toggle = 1'b1;
                end
              end else if (adc_value_i <= cfg_i.trigger_threshold) begin
                state_o.ticks    = state_i.ticks + {32'd0, interval_inc};
                state_o.interval = 16'd0;
                state_o.timer    = 16'd1;
              end
              wr_pos_o           = pos_inc(wr_pos_i);
              result_o.buf_write = 1'b1;
              result_o.buf_index = 8'(wr_pos_o);
              result_o.buf_byte  = adc_value_i[7:0] & ByteMask;
            end
            MODE_UNSTABLE: begin
              state_o.mode = MODE_ONE_SHOT;
            end
            MODE_ONE_SHOT: begin
              if (state_i.slot == cfg_i.thermistor_slot) begin
                state_o.therm = state_i.therm + {6'd0, adc_value_i};
              end else if (state_i.slot == cfg_i.humidity_slot) begin
                state_o.hum = state_i.hum + {6'd0, adc_value_i};
              end
              state_o.os_cnt = os_inc;
              if (os_inc >= {1'b0, cfg_i.oversample_count}) begin
                state_o.os_cnt = 8'd0;
                if (slot_inc >= 4'(SENSOR_SLOTS)) begin
                  state_o.mode = MODE_DONE;
                  state_o.slot = 3'd0;
                end else begin
                  state_o.slot = slot_inc[2:0];
                  state_o.mode = MODE_UNSTABLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_START: begin
        if (!state_i.started) begin
          state_o.started = 1'b1;
          wr_pos_o        = '0;
          state_o.timer   = 16'd0;
          state_o.mode    = MODE_TESTING;
          state_o.slot    = 3'd0;
          state_o.try_cnt = 16'd0;
        end
      end
      REQ_ACK: begin
        if ((state_i.mode == MODE_IDLE || state_i.mode == MODE_DONE) && state_i.started) begin
          state_o.mode = MODE_CONTINUOUS;
        end
      end
      default: ;
    endcase

    result_o.mode                = state_o.mode;
    result_o.mux_slot            = state_o.slot;
    result_o.capture_phase       = 8'(pos_inc(wr_pos_o));
    result_o.trigger_ticks_total = state_o.ticks;
    result_o.thermistor_sum      = state_o.therm;
    result_o.humidity_sum        = state_o.hum;
    result_o.adc_disable         = (state_o.mode == MODE_ERROR);
  end

endmodule

[tb/triggered_adc_capture_sequencer_tb.sv]
// self-checking testbench for the triggered adc capture sequencer stream block
`timescale 1ns / 1ps

module triggered_adc_capture_sequencer_tb;
  import tacs_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned MaxReports = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;  // adc_value
  logic [1:0]           s_axis_tuser;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // mode, mux_slot, buf_write, buf_index, buf_byte, capture_phase,
  // trigger_ticks_total, thermistor_sum, humidity_sum, adc_disable, capture_done_toggle
  logic [OutDataW-1:0]  m_axis_tdata;

  triggered_adc_capture_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // sequencer mirror
  tacs_cfg_t   cfg_now;
  mode_e       seq_mode;
  bit          armed;
  logic [15:0] tries_used;
  logic [15:0] cap_timer;
  logic [15:0] since_trig;
  logic [7:0]  wr_pos;
  logic [47:0] tick_sum;
  logic [2:0]  cur_slot;
  logic [7:0]  os_seen;
  logic [15:0] therm_total;
  logic [15:0] hum_total;

  tacs_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  cycles;
  bit           calm;
  bit           done_hit;
  bit           held;

  typedef struct {
    logic [1:0] req;
    logic [9:0] val;
    bit         typed;
    mode_e      mode;
  } dir_row_t;

  dir_row_t dir_tab [24];

  function automatic tacs_result_t step_sequencer(logic [1:0] req, logic [9:0] v);
    tacs_result_t r;
    r = '0;
    case (req)
      REQ_SAMPLE: begin
        if (armed && seq_mode != MODE_ERROR) begin
          since_trig = since_trig + 16'd1;
          case (seq_mode)
            MODE_TESTING: begin
              if (v > cfg_now.trigger_threshold) seq_mode = MODE_IDLE;
              else if (tries_used < cfg_now.max_test_tries) tries_used = tries_used + 16'd1;
              else seq_mode = MODE_ERROR;
            end
            MODE_CONTINUOUS: begin
              if (cap_timer != 16'd0) begin
                cap_timer = cap_timer + 16'd1;
                if (cap_timer == cfg_now.capture_length) begin
                  cap_timer = '0;
                  cur_slot = 3'd1;
                  therm_total = '0;
                  hum_total = '0;
                  seq_mode = MODE_UNSTABLE;
                  r.capture_done_toggle = 1'b1;
                end
              end else if (v <= cfg_now.trigger_threshold) begin
                tick_sum = tick_sum + {32'd0, since_trig};
                since_trig = '0;
                cap_timer = 16'd1;
              end
              wr_pos = wr_pos + 8'd1;
              r.buf_write = 1'b1;
              r.buf_index = wr_pos;
              r.buf_byte = v[7:0] & ByteMask;
            end
            MODE_UNSTABLE: seq_mode = MODE_ONE_SHOT;
            MODE_ONE_SHOT: begin
              if (cur_slot == cfg_now.thermistor_slot) therm_total = therm_total + {6'd0, v};
              else if (cur_slot == cfg_now.humidity_slot) hum_total = hum_total + {6'd0, v};
              os_seen = os_seen + 8'd1;
              if (os_seen >= {1'b0, cfg_now.oversample_count}) begin
                os_seen = '0;
                if (int'(cur_slot) + 1 >= int'(SensorSlotsDefault)) begin
                  seq_mode = MODE_DONE;
                  cur_slot = '0;
                end else begin
                  cur_slot = cur_slot + 3'd1;
                  seq_mode = MODE_UNSTABLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_START: begin
        if (!armed) begin
          armed = 1'b1;
          wr_pos = '0;
          cap_timer = '0;
          seq_mode = MODE_TESTING;
          cur_slot = '0;
          tries_used = '0;
        end
      end
      REQ_ACK: begin
        if (armed && (seq_mode == MODE_IDLE || seq_mode == MODE_DONE)) seq_mode = MODE_CONTINUOUS;
      end
      default: ;
    endcase
    r.mode = seq_mode;
    r.mux_slot = cur_slot;
    r.capture_phase = wr_pos + 8'd1;
    r.trigger_ticks_total = tick_sum;
    r.thermistor_sum = therm_total;
    r.humidity_sum = hum_total;
    r.adc_disable = (seq_mode == MODE_ERROR);
    return r;
  endfunction

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic check_field(string fname, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      if (mismatches < MaxReports)
        $display("mismatch in %s at result %0d: expected %h, got %h",
                 fname, results_seen, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tacs_result_t got;
    tacs_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mode                = mode_e'(m_axis_tdata[2:0]);
      got.mux_slot            = m_axis_tdata[5:3];
      got.buf_write           = m_axis_tdata[6];
      got.buf_index           = m_axis_tdata[14:7];
      got.buf_byte            = m_axis_tdata[22:15];
      got.capture_phase       = m_axis_tdata[30:23];
      got.trigger_ticks_total = m_axis_tdata[78:31];
      got.thermistor_sum      = m_axis_tdata[94:79];
      got.humidity_sum        = m_axis_tdata[110:95];
      got.adc_disable         = m_axis_tdata[111];
      got.capture_done_toggle = m_axis_tdata[112];
      if (pending_results.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected result transfer at result %0d", results_seen);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("mode", 48'(want.mode), 48'(got.mode));
        check_field("mux_slot", 48'(want.mux_slot), 48'(got.mux_slot));
        check_field("buf_write", 48'(want.buf_write), 48'(got.buf_write));
        check_field("buf_index", 48'(want.buf_index), 48'(got.buf_index));
        check_field("buf_byte", 48'(want.buf_byte), 48'(got.buf_byte));
        check_field("capture_phase", 48'(want.capture_phase), 48'(got.capture_phase));
        check_field("trigger_ticks_total", want.trigger_ticks_total, got.trigger_ticks_total);
        check_field("thermistor_sum", 48'(want.thermistor_sum), 48'(got.thermistor_sum));
        check_field("humidity_sum", 48'(want.humidity_sum), 48'(got.humidity_sum));
        check_field("adc_disable", 48'(want.adc_disable), 48'(got.adc_disable));
        check_field("capture_done_toggle", 48'(want.capture_done_toggle),
                    48'(got.capture_done_toggle));
      end
      results_seen++;
    end
  end

  // receiver, with one long hold-off so the block backs up
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TRIGGER_THRESHOLD: cfg_now.trigger_threshold = val[9:0];
      CFG_MAX_TEST_TRIES:    cfg_now.max_test_tries = val;
      CFG_CAPTURE_LENGTH:    cfg_now.capture_length = val;
      CFG_OVERSAMPLE_COUNT:  cfg_now.oversample_count = val[6:0];
      CFG_THERMISTOR_SLOT:   cfg_now.thermistor_slot = val[2:0];
      CFG_HUMIDITY_SLOT:     cfg_now.humidity_slot = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic apply_config(int unsigned thr, int unsigned tries, int unsigned len,
                              int unsigned os, int unsigned th, int unsigned hu);
    wait_drained();
    repeat (3) @(negedge clk_i);
    write_reg(CFG_TRIGGER_THRESHOLD, 16'(thr));
    write_reg(CFG_MAX_TEST_TRIES, 16'(tries));
    write_reg(CFG_CAPTURE_LENGTH, 16'(len));
    write_reg(CFG_OVERSAMPLE_COUNT, 16'(os));
    write_reg(CFG_THERMISTOR_SLOT, 16'(th));
    write_reg(CFG_HUMIDITY_SLOT, 16'(hu));
  endtask

  task automatic send_item(logic [1:0] req, logic [9:0] v, bit typed, mode_e tmode);
    tacs_result_t pred;
    tacs_result_t want;
    while (!calm && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {6'd0, v};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = step_sequencer(req, v);
    if (typed) begin
      want = '0;
      want.mode = tmode;
      want.capture_phase = 8'd1;
    end else begin
      want = pred;
    end
    pending_results.push_back(want);
    if (pred.capture_done_toggle) done_hit = 1'b1;
  endtask

  task automatic run_phase(int n_items, bit until_done);
    int i;
    int pick;
    int thr;
    logic [1:0] req;
    logic [9:0] v;
    done_hit = 1'b0;
    i = 0;
    while ((i < n_items || (until_done && !done_hit)) && i < 100000) begin
      pick = $urandom_range(99);
      thr = cfg_now.trigger_threshold;
      if (pick < 4) req = REQ_START;
      else if (pick < 8) req = REQ_UNKNOWN;
      else if (pick < 11 || ((seq_mode == MODE_IDLE || seq_mode == MODE_DONE) && pick < 60))
        req = REQ_ACK;
      else req = REQ_SAMPLE;
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = '1;
        2:       v = thr[9:0];
        3:       v = thr[9:0] + 10'd1;
        4, 5:    v = 10'($urandom_range(thr, 0));
        default: v = 10'($urandom());
      endcase
      send_item(req, v, 1'b0, MODE_IDLE);
      i++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    calm = 1'b0;
    held = 1'b0;
    done_hit = 1'b0;
    cfg_now = CFG_RESET;
    seq_mode = MODE_IDLE;
    armed = 1'b0;
    tries_used = '0;
    cap_timer = '0;
    since_trig = '0;
    wr_pos = '0;
    tick_sum = '0;
    cur_slot = '0;
    os_seen = '0;
    therm_total = '0;
    hum_total = '0;

    // before start, self-test, one full capture and sensor scan, a re-arm, ignored requests, a new trigger
    dir_tab = '{
      '{REQ_SAMPLE,  10'd1023, 1'b1, MODE_IDLE},
      '{REQ_ACK,     10'd0,    1'b1, MODE_IDLE},
      '{REQ_UNKNOWN, 10'd1023, 1'b1, MODE_IDLE},
      '{REQ_START,   10'd0,    1'b1, MODE_TESTING},
      '{REQ_SAMPLE,  10'd0,    1'b1, MODE_TESTING},
      '{REQ_START,   10'd1023, 1'b1, MODE_TESTING},
      '{REQ_SAMPLE,  10'd513,  1'b1, MODE_IDLE},
      '{REQ_ACK,     10'd0,    1'b1, MODE_CONTINUOUS},
      '{REQ_SAMPLE,  10'd1023, 1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd512,  1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'h155,  1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'h2AA,  1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd0,    1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd1023, 1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd1023, 1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd1023, 1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd0,    1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd1000, 1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd1000, 1'b0, MODE_IDLE},
      '{REQ_ACK,     10'd0,    1'b0, MODE_IDLE},
      '{REQ_ACK,     10'd0,    1'b0, MODE_IDLE},
      '{REQ_START,   10'd0,    1'b0, MODE_IDLE},
      '{REQ_UNKNOWN, 10'd0,    1'b0, MODE_IDLE},
      '{REQ_SAMPLE,  10'd0,    1'b0, MODE_IDLE}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apply_config(512, 3, 4, 2, 1, 2);
    foreach (dir_tab[k]) send_item(dir_tab[k].req, dir_tab[k].val, dir_tab[k].typed,
                                   dir_tab[k].mode);

    apply_config(512, 1000, 5, 3, 1, 2);
    run_phase(60, 1'b0);
    wait_drained();
    run_phase(90, 1'b0);

    apply_config(0, 0, 2, 1, 2, 1);
    calm = 1'b1;
    run_phase(120, 1'b0);
    calm = 1'b0;

    // same slot for both sensors
    apply_config(1023, 65535, 7, 64, 2, 2);
    run_phase(150, 1'b0);

    // capture length one never ends, oversample count zero acts as one
    apply_config(300, 1, 1, 0, 0, 7);
    run_phase(100, 1'b0);

    apply_config(700, 500, 65535, 127, 1, 3);
    run_phase(80, 1'b0);

    // capture length zero keeps the timer running until it wraps
    apply_config(0, 0, 0, 1, 1, 2);
    run_phase(40, 1'b0);

    repeat (3) begin
      apply_config($urandom_range(1023, 0), $urandom_range(65535, 0), $urandom_range(16, 2),
                   $urandom_range(8, 1), $urandom_range(7, 1), $urandom_range(7, 1));
      run_phase(110, 1'b0);
    end

    wait_drained();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tacs_pkg.sv
src/tacs_step.sv
src/triggered_adc_capture_sequencer.sv
tb/triggered_adc_capture_sequencer_tb.sv
